FILE: rtl/qsv_pkg.sv
package qsv_pkg;

    localparam int FUNC_W    = 3;
    localparam int QB_W      = 4;
    localparam int CFG_W     = 4;
    localparam int BIDX_W    = 10;
    localparam int FRAC_IN_W = 17;
    localparam int PROB_W    = 20;
    localparam int PROB_OUT_SHIFT = 16;

    localparam logic [FUNC_W-1:0] F_RESET  = 3'd0;
    localparam logic [FUNC_W-1:0] F_X      = 3'd1;
    localparam logic [FUNC_W-1:0] F_H      = 3'd2;
    localparam logic [FUNC_W-1:0] F_Z      = 3'd3;
    localparam logic [FUNC_W-1:0] F_CNOT   = 3'd4;
    localparam logic [FUNC_W-1:0] F_QUERY  = 3'd5;
    localparam logic [FUNC_W-1:0] F_SAMPLE = 3'd6;
    localparam logic [FUNC_W-1:0] F_NOP    = 3'd7;

    localparam logic [1:0] BF_PASS = 2'd0;
    localparam logic [1:0] BF_SWAP = 2'd1;
    localparam logic [1:0] BF_HAD  = 2'd2;
    localparam logic [1:0] BF_NEGB = 2'd3;

    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
    } bf_ctl_t;

endpackage

FILE: rtl/qsv_ram.sv
module qsv_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/qsv_bfly.sv
module qsv_bfly import qsv_pkg::*; #(
    parameter int AMP_BITS = 18
) (
    input  logic                       clk,
    input  bf_ctl_t                    ctl,
    input  logic signed [AMP_BITS-1:0] a_re,
    input  logic signed [AMP_BITS-1:0] a_im,
    input  logic signed [AMP_BITS-1:0] b_re,
    input  logic signed [AMP_BITS-1:0] b_im,
    output logic signed [AMP_BITS-1:0] oa_re,
    output logic signed [AMP_BITS-1:0] oa_im,
    output logic signed [AMP_BITS-1:0] ob_re,
    output logic signed [AMP_BITS-1:0] ob_im
);

    localparam int A = AMP_BITS;
    localparam logic [A:0] HI = (A+1)'((1 << (A-1)) - 1);
    localparam logic [A:0] NEG_LIM = (A+1)'(1) << (A-1);

    function automatic logic signed [A-1:0] hmul(input logic signed [A:0] v);
        logic          neg;
        logic [A:0]    m;
        logic [A+32:0] p;
        logic [A+32:0] r;
        logic [A:0]    rs;
        neg = v[A];
        m   = neg ? (A+1)'(-v) : (A+1)'(v);
        p   = (A+33)'(m) * (A+33)'(INV_SQRT2_Q32);
        r   = (p + ((A+33)'(1) << 31)) >> 32;
        rs  = r[A:0];
        if (!neg)
        begin
            hmul = (rs > HI) ? HI[A-1:0] : rs[A-1:0];
        end
        else
        begin
            hmul = (rs > NEG_LIM) ? ~HI[A-1:0] : A'(-rs);
        end
    endfunction

    function automatic logic signed [A-1:0] negs(input logic signed [A-1:0] v);
        negs = (v == ~HI[A-1:0]) ? HI[A-1:0] : -v;
    endfunction

    logic signed [A-1:0] oa_re_reg, oa_im_reg, ob_re_reg, ob_im_reg;
    logic signed [A-1:0] oa_re_next, oa_im_next, ob_re_next, ob_im_next;

    always_comb
    begin
        oa_re_next = a_re;
        oa_im_next = a_im;
        ob_re_next = b_re;
        ob_im_next = b_im;
        unique case (ctl.op)
            BF_PASS:
            begin
            end
            BF_SWAP:
            begin
                oa_re_next = b_re;
                oa_im_next = b_im;
                ob_re_next = a_re;
                ob_im_next = a_im;
            end
            BF_HAD:
            begin
                oa_re_next = hmul((A+1)'(a_re) + (A+1)'(b_re));
                oa_im_next = hmul((A+1)'(a_im) + (A+1)'(b_im));
                ob_re_next = hmul((A+1)'(a_re) - (A+1)'(b_re));
                ob_im_next = hmul((A+1)'(a_im) - (A+1)'(b_im));
            end
            BF_NEGB:
            begin
                ob_re_next = negs(b_re);
                ob_im_next = negs(b_im);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            oa_re_reg <= oa_re_next;
            oa_im_reg <= oa_im_next;
            ob_re_reg <= ob_re_next;
            ob_im_reg <= ob_im_next;
        end
    end

    assign oa_re = oa_re_reg;
    assign oa_im = oa_im_reg;
    assign ob_re = ob_re_reg;
    assign ob_im = ob_im_reg;

endmodule

FILE: rtl/qsv_prob.sv
module qsv_prob import qsv_pkg::*; #(
    parameter int AMP_BITS = 18,
    parameter int IDX_W    = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       flush,
    input  logic                       in_valid,
    input  logic [IDX_W-1:0]           in_idx,
    input  logic signed [AMP_BITS-1:0] in_re,
    input  logic signed [AMP_BITS-1:0] in_im,
    output logic                       out_valid,
    output logic [IDX_W-1:0]           out_idx,
    output logic [PROB_W-1:0]          out_prob,
    output logic signed [AMP_BITS-1:0] out_re,
    output logic signed [AMP_BITS-1:0] out_im
);

    localparam int A  = AMP_BITS;
    localparam int PS = 2 * (A - 2) - PROB_OUT_SHIFT;

    logic                v1_reg, v2_reg;
    logic [IDX_W-1:0]    idx1_reg, idx2_reg;
    logic signed [A-1:0] re1_reg, im1_reg, re2_reg, im2_reg;
    logic [2*A-1:0]      sqr_reg, sqi_reg;
    logic [PROB_W-1:0]   prob_reg;
    logic [A-1:0]        mag_re, mag_im;
    logic [2*A:0]        sum, rnd;

    always_comb
    begin
        mag_re = in_re[A-1] ? A'(-in_re) : A'(in_re);
        mag_im = in_im[A-1] ? A'(-in_im) : A'(in_im);
        sum    = (2*A+1)'(sqr_reg) + (2*A+1)'(sqi_reg);
        rnd    = (sum + ((2*A+1)'(1) << (PS - 1))) >> PS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid && !flush;
            v2_reg <= v1_reg && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        sqr_reg  <= (2*A)'(mag_re) * (2*A)'(mag_re);
        sqi_reg  <= (2*A)'(mag_im) * (2*A)'(mag_im);
        idx1_reg <= in_idx;
        re1_reg  <= in_re;
        im1_reg  <= in_im;
        prob_reg <= PROB_W'(rnd);
        idx2_reg <= idx1_reg;
        re2_reg  <= re1_reg;
        im2_reg  <= im1_reg;
    end

    assign out_valid = v2_reg;
    assign out_idx   = idx2_reg;
    assign out_prob  = prob_reg;
    assign out_re    = re2_reg;
    assign out_im    = im2_reg;

endmodule

FILE: rtl/qubit_state_vector_gate_engine_unit.sv
// Amplitudes sit in one 1-read/1-write RAM of 2^MAX_QUBITS entries. X, H, Z and CNOT
// walk every amplitude pair of the active range in turn (read a, read b, butterfly,
// write a, write b). A query reads its entry and answers once that entry has passed
// the probability pipeline; a sample streams one amplitude per cycle and answers once
// the entry that reaches the fraction has passed that pipeline. Reset and the reset
// operation run a clearing pass over all 2^MAX_QUBITS entries with busy high. Every
// accepted command yields exactly one done strobe; results cannot be held off by the
// receiver.
module qubit_state_vector_gate_engine_unit import qsv_pkg::*; #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_BITS   = 18
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic [FUNC_W-1:0]          func,
    input  logic [QB_W-1:0]            target_qubit,
    input  logic [QB_W-1:0]            control_qubit,
    input  logic [BIDX_W-1:0]          basis_index,
    input  logic [FRAC_IN_W-1:0]       random_fraction,
    output logic                       done,
    output logic [PROB_W-1:0]          probability,
    output logic signed [AMP_BITS-1:0] amp_real,
    output logic signed [AMP_BITS-1:0] amp_imag,
    output logic [BIDX_W-1:0]          sampled_index,
    output logic                       sample_found
);

    localparam int A     = AMP_BITS;
    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << AW;
    localparam int NQ_W  = $clog2(MAX_QUBITS + 1);
    localparam int CUM_W = AW + PROB_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RA   = 3'd2;
    localparam logic [2:0] S_RB   = 3'd3;
    localparam logic [2:0] S_LB   = 3'd4;
    localparam logic [2:0] S_WA   = 3'd5;
    localparam logic [2:0] S_WB   = 3'd6;
    localparam logic [2:0] S_SCAN = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    nq_cfg_reg, nq_cfg_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                clr_res_reg, clr_res_next;
    logic [FUNC_W-1:0]   op_reg, op_next;
    logic [AW-1:0]       tm_reg, tm_next;
    logic [AW-1:0]       cm_reg, cm_next;
    logic [AW-1:0]       j_reg, j_next;
    logic [AW:0]         iss_reg, iss_next;
    logic                issuing_reg, issuing_next;
    logic [CUM_W-1:0]    cum_reg, cum_next;
    logic [FRAC_IN_W-1:0] frac_reg, frac_next;
    logic                rd_v_reg, rd_v_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic signed [A-1:0] a_re_reg, a_im_reg;

    logic                done_reg, done_next;
    logic [PROB_W-1:0]   prob_reg, prob_next;
    logic signed [A-1:0] are_reg, are_next, aim_reg, aim_next;
    logic [BIDX_W-1:0]   sidx_reg, sidx_next;
    logic                sfound_reg, sfound_next;

    logic [NQ_W-1:0]     nq;
    logic [AW:0]         size;
    logic [AW:0]         last_j;
    logic [AW-1:0]       lowmask, a_addr, b_addr;
    logic                accept, cfg_wr;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [2*A-1:0]      mem_wdata, mem_rdata;
    bf_ctl_t             bf_ctl;
    logic signed [A-1:0] oa_re, oa_im, ob_re, ob_im;
    logic                flush;
    logic                pv;
    logic [AW-1:0]       pidx;
    logic [PROB_W-1:0]   pprob;
    logic signed [A-1:0] pre, pim;
    logic [CUM_W-1:0]    cum_sum;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign busy   = state_reg != S_IDLE;
    assign pready = 1'b1;
    assign prdata = 32'(nq_cfg_reg);

    always_comb
    begin
        if (nq_cfg_reg == '0)
        begin
            nq = NQ_W'(1);
        end
        else if (nq_cfg_reg > MAX_QUBITS)
        begin
            nq = NQ_W'(MAX_QUBITS);
        end
        else
        begin
            nq = NQ_W'(nq_cfg_reg);
        end
        size    = (AW+1)'(1) << nq;
        last_j  = (size >> 1) - (AW+1)'(1);
        lowmask = tm_reg - AW'(1);
        a_addr  = AW'((j_reg & ~lowmask) << 1) | (j_reg & lowmask);
        b_addr  = a_addr | tm_reg;
        cum_sum = cum_reg + CUM_W'(pprob);
    end

    always_comb
    begin
        state_next   = state_reg;
        nq_cfg_next  = nq_cfg_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_res_next = clr_res_reg;
        op_next      = op_reg;
        tm_next      = tm_reg;
        cm_next      = cm_reg;
        j_next       = j_reg;
        iss_next     = iss_reg;
        issuing_next = issuing_reg;
        cum_next     = cum_reg;
        frac_next    = frac_reg;
        rd_v_next    = 1'b0;
        rd_idx_next  = rd_idx_reg;
        done_next    = 1'b0;
        prob_next    = prob_reg;
        are_next     = are_reg;
        aim_next     = aim_reg;
        sidx_next    = sidx_reg;
        sfound_next  = sfound_reg;
        mem_we       = 1'b0;
        mem_waddr    = a_addr;
        mem_wdata    = {oa_re, oa_im};
        mem_re       = 1'b0;
        mem_raddr    = a_addr;
        bf_ctl.valid = 1'b0;
        bf_ctl.op    = BF_PASS;
        flush        = 1'b0;

        if (cfg_wr && paddr[2] == 1'b0)
        begin
            nq_cfg_next = pwdata[CFG_W-1:0];
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = (clr_cnt_reg == '0) ? {A'(1) << (A - 2), A'(0)} : '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    if (clr_res_reg)
                    begin
                        done_next   = 1'b1;
                        prob_next   = '0;
                        are_next    = '0;
                        aim_next    = '0;
                        sidx_next   = '0;
                        sfound_next = 1'b0;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = func;
                    tm_next     = AW'(1) << target_qubit;
                    cm_next     = AW'(1) << control_qubit;
                    j_next      = '0;
                    frac_next   = random_fraction;
                    prob_next   = '0;
                    are_next    = '0;
                    aim_next    = '0;
                    sidx_next   = '0;
                    sfound_next = 1'b0;
                    unique case (func)
                        F_RESET:
                        begin
                            state_next   = S_CLR;
                            clr_cnt_next = '0;
                            clr_res_next = 1'b1;
                        end
                        F_X, F_H, F_Z:
                        begin
                            if (target_qubit < nq)
                            begin
                                state_next = S_RA;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        F_CNOT:
                        begin
                            if (target_qubit < nq && control_qubit < nq
                                && target_qubit != control_qubit)
                            begin
                                state_next = S_RA;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        F_QUERY:
                        begin
                            if (basis_index < size)
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = AW'(basis_index);
                                rd_v_next    = 1'b1;
                                rd_idx_next  = AW'(basis_index);
                                issuing_next = 1'b0;
                                state_next   = S_SCAN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        F_SAMPLE:
                        begin
                            iss_next     = '0;
                            issuing_next = 1'b1;
                            cum_next     = '0;
                            state_next   = S_SCAN;
                        end
                        F_NOP:
                        begin
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RA:
            begin
                mem_re     = 1'b1;
                mem_raddr  = a_addr;
                state_next = S_RB;
            end
            S_RB:
            begin
                mem_re     = 1'b1;
                mem_raddr  = b_addr;
                state_next = S_LB;
            end
            S_LB:
            begin
                bf_ctl.valid = 1'b1;
                priority case (op_reg)
                    F_X:    bf_ctl.op = BF_SWAP;
                    F_H:    bf_ctl.op = BF_HAD;
                    F_Z:    bf_ctl.op = BF_NEGB;
                    F_CNOT: bf_ctl.op = ((a_addr & cm_reg) != '0) ? BF_SWAP : BF_PASS;
                    default: bf_ctl.op = BF_PASS;
                endcase
                state_next = S_WA;
            end
            S_WA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = a_addr;
                mem_wdata  = {oa_re, oa_im};
                state_next = S_WB;
            end
            S_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_addr;
                mem_wdata = {ob_re, ob_im};
                if ({1'b0, j_reg} == last_j)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = S_RA;
                end
            end
            S_SCAN:
            begin
                if (issuing_reg)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = iss_reg[AW-1:0];
                    rd_v_next   = 1'b1;
                    rd_idx_next = iss_reg[AW-1:0];
                    iss_next    = iss_reg + (AW+1)'(1);
                    if (iss_reg == size - (AW+1)'(1))
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (pv)
                begin
                    if (op_reg == F_QUERY)
                    begin
                        done_next  = 1'b1;
                        prob_next  = pprob;
                        are_next   = pre;
                        aim_next   = pim;
                        state_next = S_IDLE;
                        flush      = 1'b1;
                    end
                    else
                    begin
                        cum_next = cum_sum;
                        if (CUM_W'(frac_reg) <= cum_sum)
                        begin
                            done_next    = 1'b1;
                            sidx_next    = BIDX_W'(pidx);
                            sfound_next  = 1'b1;
                            state_next   = S_IDLE;
                            flush        = 1'b1;
                            issuing_next = 1'b0;
                        end
                        else if ({1'b0, pidx} == size - (AW+1)'(1))
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                            flush      = 1'b1;
                        end
                    end
                    if (flush)
                    begin
                        rd_v_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            nq_cfg_reg  <= CFG_W'(10);
            clr_cnt_reg <= '0;
            clr_res_reg <= 1'b0;
            issuing_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            nq_cfg_reg  <= nq_cfg_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_res_reg <= clr_res_next;
            issuing_reg <= issuing_next;
            rd_v_reg    <= rd_v_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        tm_reg     <= tm_next;
        cm_reg     <= cm_next;
        j_reg      <= j_next;
        iss_reg    <= iss_next;
        cum_reg    <= cum_next;
        frac_reg   <= frac_next;
        rd_idx_reg <= rd_idx_next;
        prob_reg   <= prob_next;
        are_reg    <= are_next;
        aim_reg    <= aim_next;
        sidx_reg   <= sidx_next;
        sfound_reg <= sfound_next;
        if (state_reg == S_RB)
        begin
            a_re_reg <= mem_rdata[2*A-1:A];
            a_im_reg <= mem_rdata[A-1:0];
        end
    end

    qsv_ram #(
        .WIDTH (2 * A),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    qsv_bfly #(
        .AMP_BITS (A)
    ) u_bfly (
        .clk   (clk),
        .ctl   (bf_ctl),
        .a_re  (a_re_reg),
        .a_im  (a_im_reg),
        .b_re  (mem_rdata[2*A-1:A]),
        .b_im  (mem_rdata[A-1:0]),
        .oa_re (oa_re),
        .oa_im (oa_im),
        .ob_re (ob_re),
        .ob_im (ob_im)
    );

    qsv_prob #(
        .AMP_BITS (A),
        .IDX_W    (AW)
    ) u_prob (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (flush),
        .in_valid  (rd_v_reg),
        .in_idx    (rd_idx_reg),
        .in_re     (mem_rdata[2*A-1:A]),
        .in_im     (mem_rdata[A-1:0]),
        .out_valid (pv),
        .out_idx   (pidx),
        .out_prob  (pprob),
        .out_re    (pre),
        .out_im    (pim)
    );

    assign done          = done_reg;
    assign probability   = prob_reg;
    assign amp_real      = are_reg;
    assign amp_imag      = aim_reg;
    assign sampled_index = sidx_reg;
    assign sample_found  = sfound_reg;

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_SCAN) |-> !mem_we)
        else $error("store written outside a pass");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLR || state_reg == S_WA || state_reg == S_WB))
        else $error("unexpected store write");

    a_busy_after_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WA) |=> (state_reg == S_WB))
        else $error("pair write split");

    a_found_has_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && sample_found) |-> $past(state_reg == S_SCAN))
        else $error("sample result outside scan");

endmodule
